[rtl/terminal_line_ring_buffer_defines.svh]
// assertion macros used by the terminal line ring buffer datapath
`ifndef TERMINAL_LINE_RING_BUFFER_DEFINES_SVH
`define TERMINAL_LINE_RING_BUFFER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define TLRB_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define TLRB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tlrb_pkg.sv]
// shared types, constants and pointer helpers of the terminal line ring buffer
`timescale 1ns / 1ps

package tlrb_pkg;

   // ring geometry
   localparam int RING_BYTES = 4096;
   localparam int LINE_CHUNK = 64;
   localparam int PTR_W      = $clog2(RING_BYTES);

   // field widths
   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;
   localparam int LINES_W  = 13;

   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [LINES_W-1:0]  lines_type;

   localparam lines_type LINES_MAX      = '1;
   localparam len_type   LINE_CHUNK_LEN = LEN_W'(LINE_CHUNK);

   // special keys
   localparam byte_type KEY_BACKSPACE = 8'h08;
   localparam byte_type KEY_NEWLINE   = 8'h0A;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUSH     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET_CHAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GET_LINE = 2'd2;

   // response status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;
   localparam status_type ST_NO_LINE = 2'd3;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_CHAR_START,
      OP_CHAR_TAKE,
      OP_LINE_START,
      OP_LINE_TAKE,
      OP_IGNORE
   } op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic slot_free;
      logic ring_empty;
      logic no_line;
      logic len_zero;
      logic line_fin;
   } dp_stat_type;

   // ring pointer step forward with wrap
   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // ring pointer step back with wrap
   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? PTR_W'(RING_BYTES - 1) : p - PTR_W'(1);
   endfunction

endpackage

[rtl/tlrb_req_if.sv]
// request channel interface of the terminal line ring buffer
`timescale 1ns / 1ps

interface tlrb_req_if import tlrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [BYTE_W-1:0]   char_in;
   logic [LEN_W-1:0]    max_len;

   modport source (output valid, output mode, output char_in, output max_len, input ready);
   modport sink   (input valid, input mode, input char_in, input max_len, output ready);
endinterface

[rtl/tlrb_rsp_if.sv]
// response channel interface of the terminal line ring buffer
`timescale 1ns / 1ps

interface tlrb_rsp_if import tlrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   data_out;
   logic                data_valid;
   logic [LEN_W-1:0]    count_so_far;
   logic                last;
   logic                line_wake;

   modport source (output valid, output status, output data_out, output data_valid,
                   output count_so_far, output last, output line_wake, input ready);
   modport sink   (input valid, input status, input data_out, input data_valid,
                   input count_so_far, input last, input line_wake, output ready);
endinterface

[rtl/terminal_line_ring_buffer.sv]
// Terminal input byte ring with line editing. Push requests store a byte, drop the newest
// unread byte on backspace, or are refused with a full status; a stored newline counts a
// complete line and raises line_wake on its response. Get-char returns the oldest byte, and
// get-line streams up to max_len bytes (at most LINE_CHUNK), one response transaction per
// byte with last on the final one, stopping after a newline or when the ring runs empty.
// One request is worked at a time. Get-char reads the byte ram, which has a registered read
// port, before it responds; get-line reads its first byte the same way, and the ram read of
// the next byte overlaps the output of the current one. A response register sits on the
// output, so a new request is taken in the cycle the previous response leaves. The byte ram
// needs no clearing after reset.
`timescale 1ns / 1ps

module terminal_line_ring_buffer import tlrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tlrb_req_if.sink   req_chan,
   tlrb_rsp_if.source rsp_chan
);

   op_type      op;
   dp_stat_type stat;

   // request sequencing
   tlrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .op        (op)
   );

   // ring storage and response path
   tlrb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_char_in      (req_chan.char_in),
      .req_max_len      (req_chan.max_len),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_data_out     (rsp_chan.data_out),
      .rsp_data_valid   (rsp_chan.data_valid),
      .rsp_count_so_far (rsp_chan.count_so_far),
      .rsp_last         (rsp_chan.last),
      .rsp_line_wake    (rsp_chan.line_wake),
      .stat             (stat)
   );

endmodule

[rtl/tlrb_ram.sv]
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module tlrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/tlrb_ctrl.sv]
// controller state machine of the terminal line ring buffer
`timescale 1ns / 1ps

module tlrb_ctrl import tlrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  dp_stat_type       stat,
   output op_type            op
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHAR,
      S_LINE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and operation decode
   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.slot_free;
            if (req_valid && stat.slot_free) begin
               unique case (req_mode)
                  MODE_PUSH: begin
                     op = OP_PUSH;
                  end
                  MODE_GET_CHAR: begin
                     op = OP_CHAR_START;
                     if (!stat.ring_empty) begin
                        state_in = S_CHAR;
                     end
                  end
                  MODE_GET_LINE: begin
                     op = OP_LINE_START;
                     if (!stat.no_line && !stat.len_zero && !stat.ring_empty) begin
                        state_in = S_LINE;
                     end
                  end
                  default: begin
                     op = OP_IGNORE;
                  end
               endcase
            end
         end
         S_CHAR: begin
            if (stat.slot_free) begin
               op       = OP_CHAR_TAKE;
               state_in = S_IDLE;
            end
         end
         S_LINE: begin
            if (stat.slot_free) begin
               op = OP_LINE_TAKE;
               if (stat.line_fin) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/tlrb_dp.sv]
// datapath of the terminal line ring buffer: pointers, line count, byte ram, response register
`timescale 1ns / 1ps
`include "terminal_line_ring_buffer_defines.svh"

module tlrb_dp import tlrb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   input  logic [BYTE_W-1:0]   req_char_in,
   input  logic [LEN_W-1:0]    req_max_len,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_data_valid,
   output logic [LEN_W-1:0]    rsp_count_so_far,
   output logic                rsp_last,
   output logic                rsp_line_wake,
   output dp_stat_type         stat
);

   ptr_type    head_ff, head_in;
   ptr_type    tail_ff, tail_in;
   lines_type  lines_ff, lines_in;
   len_type    n_ff, n_in;
   len_type    max_ff, max_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   byte_type   data_ff, data_in;
   logic       dvalid_ff, dvalid_in;
   len_type    count_ff, count_in;
   logic       last_ff, last_in;
   logic       wake_ff, wake_in;

   logic       ram_we;
   logic       ram_re;
   ptr_type    ram_raddr;
   byte_type   ram_rdata;

   ptr_type    head_next;
   ptr_type    tail_next;
   logic       ring_full;
   logic       ring_empty;
   logic       no_line;
   len_type    max_clamp;
   len_type    n_next;
   logic       line_fin;
   logic       slot_free;
   logic       emit;

   // ring flags
   assign head_next  = ptr_inc(head_ff);
   assign tail_next  = ptr_inc(tail_ff);
   assign ring_full  = (head_next == tail_ff);
   assign ring_empty = (head_ff == tail_ff);
   assign no_line    = (lines_ff == '0);
   assign max_clamp  = (req_max_len > LINE_CHUNK_LEN) ? LINE_CHUNK_LEN : req_max_len;
   assign n_next     = n_ff + LEN_W'(1);
   assign line_fin   = (ram_rdata == KEY_NEWLINE) || (n_next == max_ff) ||
                       (tail_next == head_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   assign stat.slot_free  = slot_free;
   assign stat.ring_empty = ring_empty;
   assign stat.no_line    = no_line;
   assign stat.len_zero   = (max_clamp == '0);
   assign stat.line_fin   = line_fin;

   // byte store
   tlrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (head_ff),
      .wdata (req_char_in),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // operation execute and response build
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      lines_in  = lines_ff;
      n_in      = n_ff;
      max_in    = max_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = tail_ff;
      emit      = 1'b0;
      status_in = ST_OK;
      data_in   = '0;
      dvalid_in = 1'b0;
      count_in  = '0;
      last_in   = 1'b1;
      wake_in   = 1'b0;
      unique case (op)
         OP_PUSH: begin
            emit = 1'b1;
            if (ring_full) begin
               status_in = ST_FULL;
            end else if (req_char_in == KEY_BACKSPACE) begin
               if (!ring_empty) begin
                  head_in = ptr_dec(head_ff);
               end
            end else begin
               ram_we  = 1'b1;
               head_in = head_next;
               if (req_char_in == KEY_NEWLINE) begin
                  wake_in = 1'b1;
                  if (lines_ff != LINES_MAX) begin
                     lines_in = lines_ff + LINES_W'(1);
                  end
               end
            end
         end
         OP_CHAR_START: begin
            if (ring_empty) begin
               emit      = 1'b1;
               status_in = ST_EMPTY;
            end else begin
               ram_re = 1'b1;
            end
         end
         OP_CHAR_TAKE: begin
            emit      = 1'b1;
            data_in   = ram_rdata;
            dvalid_in = 1'b1;
            tail_in   = tail_next;
         end
         OP_LINE_START: begin
            max_in = max_clamp;
            n_in   = '0;
            if (no_line) begin
               emit      = 1'b1;
               status_in = ST_NO_LINE;
            end else if ((max_clamp == '0) || ring_empty) begin
               emit = 1'b1;
            end else begin
               ram_re = 1'b1;
            end
         end
         OP_LINE_TAKE: begin
            emit      = 1'b1;
            data_in   = ram_rdata;
            dvalid_in = 1'b1;
            count_in  = n_next;
            last_in   = line_fin;
            tail_in   = tail_next;
            n_in      = n_next;
            if ((ram_rdata == KEY_NEWLINE) && !no_line) begin
               lines_in = lines_ff - LINES_W'(1);
            end
            // prefetch the following byte while this one goes out
            if (!line_fin) begin
               ram_re    = 1'b1;
               ram_raddr = tail_next;
            end
         end
         OP_IGNORE: begin
            emit = 1'b1;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // response register handshake
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         lines_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // line walk counters and response payload
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      max_ff <= max_in;
      if (emit) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         dvalid_ff <= dvalid_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
         wake_ff   <= wake_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_data_out     = data_ff;
   assign rsp_data_valid   = dvalid_ff;
   assign rsp_count_so_far = count_ff;
   assign rsp_last         = last_ff;
   assign rsp_line_wake    = wake_ff;

   // checks
   `TLRB_ASSERT_IMPL(a_take_not_empty, clock, reset, (op == OP_CHAR_TAKE) || (op == OP_LINE_TAKE), !ring_empty, "byte taken from an empty ring")
   `TLRB_ASSERT_IMPL(a_no_overwrite, clock, reset, emit, slot_free, "response register overwritten before transaction")
   `TLRB_ASSERT_IMPL(a_count_bound, clock, reset, op == OP_LINE_TAKE, (n_next <= max_ff) && (max_ff <= LINE_CHUNK_LEN), "line walk ran past its length")
   `TLRB_ASSERT_NEXT(a_lines_saturate, clock, reset, (lines_ff == LINES_MAX) && (op == OP_PUSH), lines_ff == LINES_MAX, "line count wrapped on push")

endmodule

[test/terminal_line_ring_buffer_tb.sv]
// self-checking testbench of the terminal line ring buffer
`timescale 1ns / 1ps

module terminal_line_ring_buffer_tb;
   import tlrb_pkg::*;

   // mode value the block answers without doing anything
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PRINT_CAP      = 60;

   // one response transaction as the block should present it
   typedef struct packed {
      status_type status;
      byte_type   data_out;
      logic       data_valid;
      len_type    count_so_far;
      logic       last;
      logic       line_wake;
   } tty_result_type;

   logic clock;
   logic reset;

   tlrb_req_if req_chan ();
   tlrb_rsp_if rsp_chan ();

   terminal_line_ring_buffer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the ring and its line counter
   byte_type  ring_mem [RING_BYTES];
   ptr_type   wr_ptr;
   ptr_type   rd_ptr;
   lines_type shadow_lines;

   tty_result_type due_responses [$];

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;
   int fail_count;
   int requests_sent;

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // report one mismatch and count it
   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // work out the responses of one accepted request and queue them
   task automatic tty_apply_request(input logic [MODE_W-1:0] m, input byte_type c,
                                    input len_type l);
      tty_result_type r;
      int             lim;
      int             n;
      bit             done;
      byte_type       b;
      r = '0;
      r.last = 1'b1;
      r.status = ST_OK;
      case (m)
         MODE_PUSH: begin
            if (ptr_type'(wr_ptr + 1'b1) == rd_ptr) begin
               r.status = ST_FULL;
            end else if (c == KEY_BACKSPACE) begin
               if (wr_ptr != rd_ptr)
                  wr_ptr = ptr_type'(wr_ptr - 1'b1);
            end else begin
               ring_mem[wr_ptr] = c;
               wr_ptr = ptr_type'(wr_ptr + 1'b1);
               if (c == KEY_NEWLINE) begin
                  if (shadow_lines != LINES_MAX)
                     shadow_lines = shadow_lines + LINES_W'(1);
                  r.line_wake = 1'b1;
               end
            end
            due_responses.push_back(r);
         end
         MODE_GET_CHAR: begin
            if (wr_ptr == rd_ptr) begin
               r.status = ST_EMPTY;
            end else begin
               r.data_out = ring_mem[rd_ptr];
               r.data_valid = 1'b1;
               rd_ptr = ptr_type'(rd_ptr + 1'b1);
            end
            due_responses.push_back(r);
         end
         MODE_GET_LINE: begin
            if (shadow_lines == '0) begin
               r.status = ST_NO_LINE;
               due_responses.push_back(r);
            end else begin
               lim = (int'(l) > LINE_CHUNK) ? LINE_CHUNK : int'(l);
               n = 0;
               done = 1'b0;
               while (!done && n < lim && wr_ptr != rd_ptr) begin
                  b = ring_mem[rd_ptr];
                  rd_ptr = ptr_type'(rd_ptr + 1'b1);
                  n++;
                  r.data_out = b;
                  r.data_valid = 1'b1;
                  r.count_so_far = len_type'(n);
                  r.last = (b == KEY_NEWLINE) || (n == lim) || (wr_ptr == rd_ptr);
                  due_responses.push_back(r);
                  if (b == KEY_NEWLINE) begin
                     if (shadow_lines != '0)
                        shadow_lines = shadow_lines - LINES_W'(1);
                     done = 1'b1;
                  end
               end
               // nothing returned: a single empty ok response
               if (n == 0) begin
                  r = '0;
                  r.last = 1'b1;
                  due_responses.push_back(r);
               end
            end
         end
         default: due_responses.push_back(r);
      endcase
   endtask

   // offer one request, with random gaps, and predict it once accepted
   task automatic send_request(input logic [MODE_W-1:0] m, input byte_type c,
                               input len_type l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= m;
      req_chan.char_in <= c;
      req_chan.max_len <= l;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      tty_apply_request(m, c, l);
      requests_sent++;
   endtask

   // lower valid and wait until every queued response has arrived
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic push_byte(input byte_type c);
      send_request(MODE_PUSH, c, len_type'($urandom_range(0, 127)));
   endtask

   task automatic get_line(input len_type l);
      send_request(MODE_GET_LINE, byte_type'($urandom_range(0, 255)), l);
   endtask

   task automatic get_char();
      send_request(MODE_GET_CHAR, byte_type'($urandom_range(0, 255)),
                   len_type'($urandom_range(0, 127)));
   endtask

   // reads and pushes on an empty ring, and the ignored mode
   task automatic test_empty_ring();
      get_char();
      get_line(len_type'(64));
      get_line(len_type'(0));
      push_byte(KEY_BACKSPACE);
      send_request(MODE_IGNORED, 8'hFF, 7'h7F);
      send_request(MODE_IGNORED, 8'h00, 7'h00);
      wait_drained();
   endtask

   // line assembly, backspace and the get-line limits
   task automatic test_line_editing();
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h61);
      push_byte(KEY_BACKSPACE);
      push_byte(KEY_NEWLINE);
      // zero length read with a line waiting
      get_line(len_type'(0));
      get_line(len_type'(1));
      get_line(7'h7F);
      push_byte(8'h78);
      push_byte(KEY_NEWLINE);
      // backspace over a newline keeps the line counted
      push_byte(KEY_BACKSPACE);
      get_line(len_type'(64));
      // counted line with the ring empty
      get_line(len_type'(65));
      push_byte(KEY_NEWLINE);
      get_char();
      get_line(len_type'(64));
      wait_drained();
   endtask

   // receiver stalls for a long stretch while requests keep coming
   task automatic test_receiver_hold();
      hold_request = 1'b1;
      push_byte(8'h68);
      push_byte(8'h69);
      push_byte(KEY_NEWLINE);
      get_line(len_type'(64));
      push_byte(8'h21);
      get_char();
      get_char();
      get_line(len_type'(64));
      wait_drained();
   endtask

   // mostly well-formed lines with random content, some noise
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int items);
      int       stop_at;
      int       n_chars;
      byte_type c;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = requests_sent + items;
      while (requests_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(MODE_W'($urandom_range(0, 3)), byte_type'($urandom_range(0, 255)),
                         len_type'($urandom_range(0, 127)));
         end else begin
            n_chars = $urandom_range(0, 12);
            repeat (n_chars) begin
               if ($urandom_range(0, 9) == 0)
                  c = KEY_BACKSPACE;
               else
                  c = byte_type'($urandom_range(0, 255));
               push_byte(c);
            end
            if ($urandom_range(0, 4) != 0)
               push_byte(KEY_NEWLINE);
            case ($urandom_range(0, 5))
               0: repeat ($urandom_range(1, 4)) get_char();
               1: get_line(len_type'($urandom_range(0, 127)));
               default: get_line(len_type'($urandom_range(1, 64)));
            endcase
         end
      end
      wait_drained();
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // response check against the oldest queued expectation
   always @(posedge clock) begin
      tty_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_responses.size() == 0) begin
            report_mismatch("response transaction with nothing expected");
         end else begin
            want = due_responses.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_chan.status, want.status));
            if (rsp_chan.data_out !== want.data_out)
               report_mismatch($sformatf("data_out got %0h want %0h",
                                         rsp_chan.data_out, want.data_out));
            if (rsp_chan.data_valid !== want.data_valid)
               report_mismatch($sformatf("data_valid got %0b want %0b",
                                         rsp_chan.data_valid, want.data_valid));
            if (rsp_chan.count_so_far !== want.count_so_far)
               report_mismatch($sformatf("count_so_far got %0d want %0d",
                                         rsp_chan.count_so_far, want.count_so_far));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("last got %0b want %0b",
                                         rsp_chan.last, want.last));
            if (rsp_chan.line_wake !== want.line_wake)
               report_mismatch($sformatf("line_wake got %0b want %0b",
                                         rsp_chan.line_wake, want.line_wake));
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("terminal_line_ring_buffer verification failed");
      $finish;
   end

   // test sequence
   initial begin
      reset = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.mode    <= MODE_PUSH;
      req_chan.char_in <= '0;
      req_chan.max_len <= '0;
      wr_ptr = '0;
      rd_ptr = '0;
      shadow_lines = '0;
      fail_count = 0;
      requests_sent = 0;
      hold_request = 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 71;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_ring();
      test_line_editing();
      test_receiver_hold();
      test_random_traffic(37, 71, 105);
      test_random_traffic(71, 37, 105);
      test_random_traffic(0, 0, 105);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
      if (fail_count == 0)
         $display("terminal_line_ring_buffer verification clean");
      else
         $display("terminal_line_ring_buffer verification failed");
      $finish;
   end

endmodule
